@@ src/wbs_pkg.sv @@
// Shared types and constants of the weighted bin sampler.
`timescale 1ns / 1ps
`default_nettype none
package wbs_pkg;

	localparam logic [1:0] KIND_LOAD = 2'd0;
	localparam logic [1:0] KIND_DRAW = 2'd1;
	localparam logic [1:0] KIND_TAKE = 2'd2;

	localparam int DIGIT_BITS = 8;

	typedef struct packed {
		logic acc_clr;
		logic acc_add;
		logic mul_load;
		logic mul_step;
	} wbs_mac_ctl_t;

	typedef struct packed {
		logic total_zero;
		logic below;
	} wbs_mac_sts_t;

endpackage
`default_nettype wire

@@ src/wbs_ram.sv @@
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
`default_nettype none
module wbs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

@@ src/wbs_mac.sv @@
// Shared accumulator, digit-serial multiplier and threshold compare.
`timescale 1ns / 1ps
`default_nettype none
module wbs_mac
	import wbs_pkg::*;
#(
	parameter int BINS          = 16,
	parameter int WEIGHT_BITS   = 16,
	parameter int FRACTION_BITS = 16
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire wbs_mac_ctl_t             ctl,
	input  wire logic [WEIGHT_BITS-1:0]   w_eff,
	input  wire logic [FRACTION_BITS-1:0] u_in,
	output wbs_mac_sts_t                  sts
);

	localparam int SUM_W = WEIGHT_BITS + $clog2(BINS);
	localparam int UD    = (FRACTION_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
	localparam int U_PAD = UD * DIGIT_BITS;
	localparam int PW    = U_PAD + SUM_W;

	logic [SUM_W-1:0]            acc_q;
	logic [U_PAD-1:0]            u_q;
	logic [PW-1:0]               prod_q;
	logic [SUM_W-1:0]            acc_next;
	logic [SUM_W-1:0]            thr;
	logic [DIGIT_BITS-1:0]       digit;
	logic [SUM_W+DIGIT_BITS-1:0] pp;

	assign acc_next = acc_q + SUM_W'(w_eff);
	assign thr      = prod_q[FRACTION_BITS +: SUM_W];
	assign digit    = u_q[U_PAD-1 -: DIGIT_BITS];
	assign pp       = (SUM_W + DIGIT_BITS)'(acc_q) * (SUM_W + DIGIT_BITS)'(digit);

	assign sts.total_zero = (acc_q == '0);
	assign sts.below      = (thr < acc_next);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.acc_clr) begin
			acc_q <= '0;
		end else if (ctl.acc_add) begin
			acc_q <= acc_next;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.mul_load) begin
			u_q    <= U_PAD'(u_in);
			prod_q <= '0;
		end else if (ctl.mul_step) begin
			u_q    <= u_q << DIGIT_BITS;
			prod_q <= (prod_q << DIGIT_BITS) + PW'(pp);
		end
	end

endmodule
`default_nettype wire

@@ src/weighted_bin_sampler_top.sv @@
// Top level of the weighted bin sampler: sequencer, weight table and valid bits.
//
// Roulette-wheel selection over a table of BINS weights. A load item writes one
// weight, and the input stays ready. A draw with n active bins keeps the input
// busy after its transfer: it sums the n weights through the one registered read
// port of the table, forms the threshold in the shared 8-bit digit multiplier
// over D = ceil(FRACTION_BITS / 8) digits, rescans the running sum, and hands
// over the result, clearing the chosen bin for a take that finds one. A draw
// over a zero total skips the rescan. The hand-over waits while the previous
// result is still held in the output register, and the input is not ready until
// the draw has moved into it.
`timescale 1ns / 1ps
`default_nettype none
module weighted_bin_sampler_top
	import wbs_pkg::*;
#(
	parameter int BINS          = 16,
	parameter int WEIGHT_BITS   = 16,
	parameter int FRACTION_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [4:0]  cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  kind,
	input  wire logic [3:0]  bin_index,
	input  wire logic [15:0] weight,
	input  wire logic [15:0] uniform,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [3:0]       chosen_bin,
	output logic             found
);

	localparam int IDX_W = (BINS > 1) ? $clog2(BINS) : 1;
	localparam int CNT_W = $clog2(BINS + 1);
	localparam int UD    = (FRACTION_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
	localparam int DIG_W = (UD > 1) ? $clog2(UD) : 1;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_SUM  = 5'b00010,
		S_MUL  = 5'b00100,
		S_SCAN = 5'b01000,
		S_FIN  = 5'b10000
	} state_t;

	state_t             state_q;
	logic [4:0]         active_q;
	logic [CNT_W-1:0]   n_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               pend_q;
	logic [IDX_W-1:0]   pidx_q;
	logic [IDX_W-1:0]   pick_q;
	logic               hit_q;
	logic               take_q;
	logic [DIG_W-1:0]   dig_q;
	logic [BINS-1:0]    vld_q;
	logic               rvld_q;

	logic               accept;
	logic               is_draw;
	logic               rd_en;
	logic               out_free;
	logic [IDX_W-1:0]   raddr;
	logic [WEIGHT_BITS-1:0] rdata;
	logic [WEIGHT_BITS-1:0] w_eff;
	logic               we;
	logic [IDX_W-1:0]   waddr;
	logic [WEIGHT_BITS-1:0] wdata;
	logic [31:0]        w32;
	logic [31:0]        u32;
	logic [31:0]        b32;
	logic [31:0]        p32;
	logic [31:0]        n32;
	wbs_mac_ctl_t       mac_ctl;
	wbs_mac_sts_t       mac_sts;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign is_draw  = (kind == KIND_DRAW) || (kind == KIND_TAKE);
	assign out_free = !out_valid || out_ready;
	assign w32      = 32'(weight);
	assign u32      = 32'(uniform);
	assign b32      = 32'(bin_index);
	assign p32      = 32'(pick_q);
	assign raddr    = cnt_q[IDX_W-1:0];
	assign w_eff    = rvld_q ? rdata : '0;

	always_comb begin
		if (active_q == '0) begin
			n32 = 32'd1;
		end else if (32'(active_q) > 32'(BINS)) begin
			n32 = 32'(BINS);
		end else begin
			n32 = 32'(active_q);
		end
	end

	always_comb begin
		rd_en = 1'b0;
		case (state_q)
			S_SUM:   rd_en = (cnt_q < n_q);
			S_SCAN:  rd_en = (cnt_q < n_q) && !(pend_q && mac_sts.below);
			default: rd_en = 1'b0;
		endcase
	end

	always_comb begin
		we    = 1'b0;
		waddr = b32[IDX_W-1:0];
		wdata = w32[WEIGHT_BITS-1:0];
		if (accept && (kind == KIND_LOAD) && (b32 < 32'(BINS))) begin
			we = 1'b1;
		end else if ((state_q == S_FIN) && out_free && take_q && hit_q) begin
			we    = 1'b1;
			waddr = pick_q;
			wdata = '0;
		end
	end

	always_comb begin
		mac_ctl = '0;
		case (state_q)
			S_IDLE: begin
				mac_ctl.acc_clr  = accept;
				mac_ctl.mul_load = accept;
			end
			S_SUM: begin
				mac_ctl.acc_add = pend_q;
			end
			S_MUL: begin
				mac_ctl.mul_step = 1'b1;
				mac_ctl.acc_clr  = (dig_q == DIG_W'(UD - 1));
			end
			S_SCAN: begin
				mac_ctl.acc_add = pend_q;
			end
			default: mac_ctl = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 5'd16;
		end else if (cfg_we) begin
			active_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (we) begin
			vld_q[waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		rvld_q <= vld_q[raddr];
		if (rd_en) begin
			pidx_q <= raddr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			n_q        <= '0;
			cnt_q      <= '0;
			pend_q     <= 1'b0;
			pick_q     <= '0;
			hit_q      <= 1'b0;
			take_q     <= 1'b0;
			dig_q      <= '0;
			out_valid  <= 1'b0;
			chosen_bin <= '0;
			found      <= 1'b0;
		end else begin
			if (out_valid && out_ready && (state_q != S_FIN)) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept && is_draw) begin
						state_q <= S_SUM;
						n_q     <= n32[CNT_W-1:0];
						cnt_q   <= '0;
						pend_q  <= 1'b0;
						pick_q  <= '0;
						hit_q   <= 1'b0;
						take_q  <= (kind == KIND_TAKE);
					end
				end
				S_SUM: begin
					pend_q <= rd_en;
					if (rd_en) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end else if (!pend_q) begin
						state_q <= S_MUL;
						dig_q   <= '0;
					end
				end
				S_MUL: begin
					dig_q <= dig_q + DIG_W'(1);
					if (dig_q == DIG_W'(UD - 1)) begin
						cnt_q  <= '0;
						pend_q <= 1'b0;
						if (mac_sts.total_zero) begin
							state_q <= S_FIN;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					pend_q <= rd_en;
					if (rd_en) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
					if (pend_q && mac_sts.below) begin
						state_q <= S_FIN;
						pick_q  <= pidx_q;
						hit_q   <= 1'b1;
					end else if (!rd_en && !pend_q) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						out_valid  <= 1'b1;
						chosen_bin <= p32[3:0];
						found      <= hit_q;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	wbs_ram #(
		.WIDTH (WEIGHT_BITS),
		.DEPTH (BINS)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	wbs_mac #(
		.BINS          (BINS),
		.WEIGHT_BITS   (WEIGHT_BITS),
		.FRACTION_BITS (FRACTION_BITS)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.w_eff  (w_eff),
		.u_in   (u32[FRACTION_BITS-1:0]),
		.sts    (mac_sts)
	);

`ifndef SYNTHESIS
	a_pick_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && hit_q) |-> (32'(pick_q) < 32'(n_q)))
		else $error("Chosen bin lies outside the active set.");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SUM || state_q == S_SCAN) |-> (cnt_q <= n_q))
		else $error("Read counter ran past the active bins.");

	a_draw_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_draw) |=> !in_ready)
		else $error("Input stayed ready after a draw transfer.");

	a_fin_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN) |-> ($past(state_q) == S_MUL || $past(state_q) == S_SCAN
			|| $past(state_q) == S_FIN))
		else $error("Result stage entered without a finished scan.");
`endif

endmodule
`default_nettype wire
